// ===== design/sphere_spiral_point_generator_assert.svh =====
// Assertion macros for the sphere spiral point generator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SPHERE_SPIRAL_POINT_GENERATOR_ASSERT_SVH
`define SPHERE_SPIRAL_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define SSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ssp_pkg.sv =====
// Shared types, constants and tables of the sphere spiral point generator.
// No dependencies.
package ssp_pkg;

	localparam int COORD_FRAC_BITS = 14;
	localparam int PHASE_BITS      = 24;
	localparam int COORD_W         = 16;
	localparam int CNT_W           = 16;
	localparam int IDX_W           = CNT_W + 1;
	localparam int A_W             = IDX_W + 1;
	localparam int CFG_W           = 24;
	localparam int CFG_IW          = 2;
	localparam int ANGLE_W         = 24;

	localparam int DIV_NW = 56;
	localparam int DIV_DW = 33;
	localparam int DIV_QW = 32;
	localparam int DIV_CW = $clog2(DIV_NW);

	localparam int SQ_IW = 64;
	localparam int SQ_RW = SQ_IW / 2;
	localparam int SQ_CW = $clog2(SQ_IW / 2);

	localparam int CD_W     = 34;
	localparam int CD_ITERS = 30;
	localparam int CD_CW    = $clog2(CD_ITERS);

	localparam int Q_DEPTH = 2;
	localparam int Q_PW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [30:0] STEP_K = 31'd1230417496;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic signed [CD_W-1:0] CORDIC_GAIN = CD_W'(652032874);
	localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(1 << COORD_FRAC_BITS);

	typedef enum logic [CFG_IW-1:0] {
		REG_POINT_COUNT,
		REG_POLES,
		REG_FIXED_EN,
		REG_FIXED_ANGLE
	} cfg_reg_t;

	typedef struct packed {
		logic [CNT_W-1:0]   point_count;
		logic               poles;
		logic               fixed_en;
		logic [ANGLE_W-1:0] fixed_angle;
	} ssp_cfg_t;

	typedef struct packed {
		logic                  pole;
		logic                  north;
		logic                  first;
		logic                  last;
		logic signed [A_W-1:0] a;
		logic [IDX_W-1:0]      d;
		logic [IDX_W-1:0]      n_int;
		logic [IDX_W-1:0]      i_int;
	} ssp_desc_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_YDIV_GO,
		B_YDIV_WAIT,
		B_RSQ_GO,
		B_RSQ_WAIT,
		B_MUL1,
		B_MUL2,
		B_MSQ_GO,
		B_MSQ_WAIT,
		B_QDIV_GO,
		B_QDIV_WAIT,
		B_PHASE,
		B_ANGLE,
		B_ROT_GO,
		B_ROT_WAIT,
		B_SCALE
	} back_state_t;

	function automatic logic signed [CD_W-1:0] atan_q30(input logic [CD_CW-1:0] k);
		logic signed [CD_W-1:0] v;
		case (k)
			5'd0:  v = CD_W'(843314857);
			5'd1:  v = CD_W'(497837829);
			5'd2:  v = CD_W'(263043837);
			5'd3:  v = CD_W'(133525159);
			5'd4:  v = CD_W'(67021687);
			5'd5:  v = CD_W'(33543516);
			5'd6:  v = CD_W'(16775851);
			5'd7:  v = CD_W'(8388437);
			5'd8:  v = CD_W'(4194283);
			5'd9:  v = CD_W'(2097149);
			default: begin
				if (k < CD_CW'(CD_ITERS))
					v = CD_W'(1) <<< (30 - int'(k));
				else
					v = '0;
			end
		endcase
		return v;
	endfunction

	function automatic logic [PHASE_BITS-1:0] fixed_step(input logic [ANGLE_W-1:0] fa);
		logic [63:0] w;
		w = 64'(fa);
		if (PHASE_BITS >= ANGLE_W)
			w = w << (PHASE_BITS - ANGLE_W);
		else
			w = w >> (ANGLE_W - PHASE_BITS);
		return w[PHASE_BITS-1:0];
	endfunction

endpackage

// ===== design/ssp_front.sv =====
// Front end: accepts step requests, tracks the point index, classifies each point.
// Depends on ssp_pkg.
module ssp_front import ssp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ssp_cfg_t  cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      restart,
	output logic      push,
	output ssp_desc_t push_desc,
	input  logic      q_full
);

	logic [IDX_W-1:0] point_index_q;
	logic [IDX_W-1:0] n_eff, k, n_int, i_int, d;
	logic             last;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		n_eff = (cfg.point_count == '0) ? IDX_W'(1) : {1'b0, cfg.point_count};
		k     = (restart || (point_index_q >= n_eff)) ? '0 : point_index_q;
		last  = (k == n_eff - IDX_W'(1));
		n_int = cfg.poles ? n_eff : n_eff + IDX_W'(2);
		i_int = cfg.poles ? k : k + IDX_W'(1);
		d     = n_int - IDX_W'(1);
		push_desc.pole  = cfg.poles && ((k == '0) || last);
		push_desc.north = (k != '0);
		push_desc.first = (k == '0);
		push_desc.last  = last;
		push_desc.a     = $signed({i_int, 1'b0} - {1'b0, d});
		push_desc.d     = d;
		push_desc.n_int = n_int;
		push_desc.i_int = i_int;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_index_q <= '0;
		end else if (push) begin
			point_index_q <= last ? '0 : k + IDX_W'(1);
		end
	end

endmodule

// ===== design/ssp_queue.sv =====
// Two-entry queue of point descriptors between front and back end.
// Depends on ssp_pkg.
module ssp_queue import ssp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssp_desc_t       push_desc,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output ssp_desc_t       pop_desc,
	output logic [Q_CW-1:0] count
);

	ssp_desc_t         entry_q [Q_DEPTH];
	logic [Q_PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0]   count_q;

	assign full      = (count_q == Q_CW'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_desc  = entry_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_PW'(1);
			if (push && !pop)
				count_q <= count_q + Q_CW'(1);
			else if (pop && !push)
				count_q <= count_q - Q_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_desc;
	end

endmodule

// ===== design/ssp_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on ssp_pkg.
module ssp_div import ssp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_QW-1:0] quo
);

	logic              run_q, done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] num_q, quo_q;
	logic [DIV_DW-1:0] den_q, rem_q;
	logic [DIV_DW:0]   trial;
	logic              take;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign take  = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quo   = quo_q[DIV_QW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CW'(1);
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[DIV_NW-2:0], 1'b0};
			rem_q <= take ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], take};
		end
	end

endmodule

// ===== design/ssp_isqrt.sv =====
// Integer square root, one result bit per cycle.
// Depends on ssp_pkg.
module ssp_isqrt import ssp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_IW-1:0] val,
	output logic             done,
	output logic [SQ_RW-1:0] root
);

	localparam logic [SQ_IW-1:0] SQ_TOP = SQ_IW'(1) << (SQ_IW - 2);

	logic             run_q, done_q;
	logic [SQ_CW-1:0] cnt_q;
	logic [SQ_IW-1:0] v_q, res_q, bitv;
	logic [SQ_IW:0]   sum;
	logic             take;

	assign bitv = SQ_TOP >> {cnt_q, 1'b0};
	assign sum  = {1'b0, res_q} + {1'b0, bitv};
	assign take = ({1'b0, v_q} >= sum);
	assign done = done_q;
	assign root = res_q[SQ_RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + SQ_CW'(1);
				if (cnt_q == SQ_CW'(SQ_IW / 2 - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= val;
			res_q <= '0;
		end else if (run_q) begin
			if (take) begin
				v_q   <= v_q - sum[SQ_IW-1:0];
				res_q <= (res_q >> 1) + bitv;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

endmodule

// ===== design/ssp_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per cycle, Q30 values.
// Depends on ssp_pkg.
module ssp_cordic import ssp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [CD_W-1:0] z_in,
	output logic                   done,
	output logic signed [CD_W-1:0] cos_out,
	output logic signed [CD_W-1:0] sin_out
);

	logic                   run_q, done_q;
	logic [CD_CW-1:0]       cnt_q;
	logic signed [CD_W-1:0] x_q, y_q, z_q, dx, dy, at;

	assign dx      = y_q >>> cnt_q;
	assign dy      = x_q >>> cnt_q;
	assign at      = atan_q30(cnt_q);
	assign done    = done_q;
	assign cos_out = x_q;
	assign sin_out = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CD_CW'(1);
				if (cnt_q == CD_CW'(CD_ITERS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= z_in;
		end else if (run_q) begin
			if (!z_q[CD_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

endmodule

// ===== design/ssp_back.sv =====
// Back end: sequences divider, square root and CORDIC to form each non-pole point.
// Depends on ssp_pkg, ssp_div, ssp_isqrt and ssp_cordic.
module ssp_back import ssp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ssp_cfg_t                  cfg,
	input  logic                      q_valid,
	input  ssp_desc_t                 q_desc,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] x_coord,
	output logic signed [COORD_W-1:0] y_coord,
	output logic signed [COORD_W-1:0] z_coord,
	output logic                      last_point
);

	localparam int SC_W = CD_W + COORD_W + 1;
	localparam logic signed [SC_W-1:0] SC_HALF = SC_W'(1 << 29);
	localparam logic signed [SC_W-1:0] SC_ONE  = SC_W'(1 << COORD_FRAC_BITS);

	back_state_t state_q, state_d;

	ssp_desc_t                 desc_q;
	logic                      out_valid_q, last_q;
	logic signed [COORD_W-1:0] x_q, y_q, z_q, yp_q;
	logic [COORD_W-1:0]        mag_q, r_q, mag;
	logic [2*IDX_W-1:0]        prod1_q;
	logic [3*IDX_W-1:0]        m_q;
	logic [SQ_RW-1:0]          root_q;
	logic [DIV_QW-1:0]         q_q;
	logic [PHASE_BITS-1:0]     phase_q, phase_base, step;
	logic signed [CD_W-1:0]    z0_q, cd_cos, cd_sin, s_val, c_val;
	logic [A_W-1:0]            amag;
	logic [29:0]               r32;
	logic [61:0]               ang_prod;
	logic [1:0]                quad;

	logic              div_start, div_done, sq_start, sq_done, cd_start, cd_done;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic [DIV_QW-1:0] div_quo;
	logic [SQ_IW-1:0]  sq_in;
	logic [SQ_RW-1:0]  sq_root;

	function automatic logic signed [COORD_W-1:0] scale(input logic signed [CD_W-1:0] t,
			input logic [COORD_W-1:0] r);
		logic signed [SC_W-1:0] p, v;
		p = t * $signed({1'b0, r});
		v = (p + SC_HALF) >>> 30;
		if (v > SC_ONE)
			v = SC_ONE;
		if (v < -SC_ONE)
			v = -SC_ONE;
		return v[COORD_W-1:0];
	endfunction

	ssp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	ssp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.val    (sq_in),
		.done   (sq_done),
		.root   (sq_root)
	);

	ssp_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cd_start),
		.z_in    (z0_q),
		.done    (cd_done),
		.cos_out (cd_cos),
		.sin_out (cd_sin)
	);

	assign out_valid  = out_valid_q;
	assign x_coord    = x_q;
	assign y_coord    = y_q;
	assign z_coord    = z_q;
	assign last_point = last_q;

	always_comb begin
		amag       = desc_q.a[A_W-1] ? A_W'(-desc_q.a) : A_W'(desc_q.a);
		mag        = div_quo[COORD_W-1:0];
		phase_base = desc_q.first ? '0 : phase_q;
		step       = cfg.fixed_en ? fixed_step(cfg.fixed_angle)
		                          : q_q[DIV_QW-1 -: PHASE_BITS];
		r32        = 30'(phase_q[PHASE_BITS-3:0]) << (32 - PHASE_BITS);
		ang_prod   = r32 * PI_Q30;
		quad       = phase_q[PHASE_BITS-1 -: 2];
		case (quad)
			2'd0: begin
				s_val = cd_sin;
				c_val = cd_cos;
			end
			2'd1: begin
				s_val = cd_cos;
				c_val = -cd_sin;
			end
			2'd2: begin
				s_val = -cd_sin;
				c_val = -cd_cos;
			end
			default: begin
				s_val = -cd_cos;
				c_val = cd_sin;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (q_valid && !out_valid_q && !q_desc.pole)
					state_d = B_YDIV_GO;
			end
			B_YDIV_GO:   state_d = B_YDIV_WAIT;
			B_YDIV_WAIT: if (div_done) state_d = B_RSQ_GO;
			B_RSQ_GO:    state_d = B_RSQ_WAIT;
			B_RSQ_WAIT: begin
				if (sq_done)
					state_d = cfg.fixed_en ? B_PHASE : B_MUL1;
			end
			B_MUL1:      state_d = B_MUL2;
			B_MUL2:      state_d = B_MSQ_GO;
			B_MSQ_GO:    state_d = B_MSQ_WAIT;
			B_MSQ_WAIT:  if (sq_done) state_d = B_QDIV_GO;
			B_QDIV_GO:   state_d = (root_q == '0) ? B_PHASE : B_QDIV_WAIT;
			B_QDIV_WAIT: if (div_done) state_d = B_PHASE;
			B_PHASE:     state_d = B_ANGLE;
			B_ANGLE:     state_d = B_ROT_GO;
			B_ROT_GO:    state_d = B_ROT_WAIT;
			B_ROT_WAIT:  if (cd_done) state_d = B_SCALE;
			B_SCALE:     state_d = B_IDLE;
			default:     state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == B_IDLE) && q_valid && !out_valid_q;
		div_start = (state_q == B_YDIV_GO) || ((state_q == B_QDIV_GO) && (root_q != '0));
		sq_start  = (state_q == B_RSQ_GO) || (state_q == B_MSQ_GO);
		cd_start  = (state_q == B_ROT_GO);
		if (state_q == B_YDIV_GO) begin
			div_num = (DIV_NW'(amag) << (COORD_FRAC_BITS + 1)) + DIV_NW'(desc_q.d);
			div_den = DIV_DW'({desc_q.d, 1'b0});
		end else begin
			div_num = {48'(STEP_K) * 48'(desc_q.d), 8'd0};
			div_den = DIV_DW'(root_q);
		end
		if (state_q == B_RSQ_GO)
			sq_in = (SQ_IW'(1) << (2 * COORD_FRAC_BITS))
				- SQ_IW'(32'(mag_q) * 32'(mag_q));
		else
			sq_in = SQ_IW'({m_q, 16'd0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			phase_q     <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (q_pop && q_desc.pole) begin
				out_valid_q <= 1'b1;
				phase_q     <= '0;
			end
			if (state_q == B_PHASE)
				phase_q <= phase_base + step;
			if (state_q == B_SCALE)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_q <= q_desc;
			last_q <= q_desc.last;
			if (q_desc.pole) begin
				x_q <= '0;
				z_q <= '0;
				y_q <= q_desc.north ? COORD_ONE : -COORD_ONE;
			end
		end
		if ((state_q == B_YDIV_WAIT) && div_done) begin
			mag_q <= mag;
			yp_q  <= desc_q.a[A_W-1] ? -$signed(mag) : $signed(mag);
		end
		if ((state_q == B_RSQ_WAIT) && sq_done)
			r_q <= sq_root[COORD_W-1:0];
		if (state_q == B_MUL1)
			prod1_q <= desc_q.n_int * desc_q.i_int;
		if (state_q == B_MUL2)
			m_q <= prod1_q * (desc_q.d - desc_q.i_int);
		if ((state_q == B_MSQ_WAIT) && sq_done)
			root_q <= sq_root;
		if ((state_q == B_QDIV_GO) && (root_q == '0))
			q_q <= '0;
		if ((state_q == B_QDIV_WAIT) && div_done)
			q_q <= div_quo;
		if (state_q == B_ANGLE)
			z0_q <= CD_W'(ang_prod[61:31]);
		if (state_q == B_SCALE) begin
			x_q <= scale(s_val, r_q);
			z_q <= scale(c_val, r_q);
			y_q <= yp_q;
		end
	end

endmodule

// ===== design/sphere_spiral_point_generator.sv =====
// Top level of the sphere spiral point generator: configuration registers,
// front end, descriptor queue and back end. Depends on ssp_pkg and all ssp_ modules.
//
// Each accepted request yields one point (x, y, z in signed Q1.14, last_point on
// the final point). A pole point is loaded directly; fixed-angle and spiral
// points are formed by the bit-serial divider (one or two quotients per point),
// the bit-serial square root (one or two per point) and the 30-step CORDIC
// rotation. Two requests queue up ahead of the back end and a finished point
// waits in the output register.
`include "sphere_spiral_point_generator_assert.svh"
module sphere_spiral_point_generator import ssp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IW-1:0]         cfg_index,
	input  logic [CFG_W-1:0]          cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      restart,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] x_coord,
	output logic signed [COORD_W-1:0] y_coord,
	output logic signed [COORD_W-1:0] z_coord,
	output logic                      last_point
);

	ssp_cfg_t        cfg_q;
	logic            push, q_full, q_pop, q_valid;
	ssp_desc_t       push_desc, pop_desc;
	logic [Q_CW-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.point_count <= CNT_W'(2);
			cfg_q.poles       <= 1'b0;
			cfg_q.fixed_en    <= 1'b0;
			cfg_q.fixed_angle <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_POINT_COUNT: cfg_q.point_count <= cfg_wdata[CNT_W-1:0];
				REG_POLES:       cfg_q.poles       <= cfg_wdata[0];
				REG_FIXED_EN:    cfg_q.fixed_en    <= cfg_wdata[0];
				REG_FIXED_ANGLE: cfg_q.fixed_angle <= cfg_wdata[ANGLE_W-1:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	ssp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.push      (push),
		.push_desc (push_desc),
		.q_full    (q_full)
	);

	ssp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_desc  (pop_desc),
		.count     (q_count)
	);

	ssp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_desc     (pop_desc),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.z_coord    (z_coord),
		.last_point (last_point)
	);

	`SSP_ASSERT_NXT(a_transfer_queued, in_valid && in_ready, q_count != '0, "accepted request not queued")
	`SSP_ASSERT_IMP(a_pole_on_axis, out_valid && (y_coord == COORD_ONE || y_coord == -COORD_ONE), x_coord == '0 && z_coord == '0, "pole point off axis")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for sphere_spiral_point_generator.
// Predicts every point in integer arithmetic and checks transfers on
// the output channel; depends on ssp_pkg and the design sources.
`timescale 1ns / 100ps
module testbench;
	import ssp_pkg::*;

	localparam int LIMIT = 3000000;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               last;
	} point_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_ready;
	logic restart = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] x_coord, y_coord, z_coord;
	logic last_point;

	sphere_spiral_point_generator u_dut (.*);

	always #5 clk = ~clk;

	logic pend_restart[$];
	point_t exp_points[$];
	int errors = 0;
	int sent = 0, taken = 0, cycles = 0;
	int send_gap = 0, recv_gap = 0, stall_left = 0;
	bit quiet = 0, stall_req = 0, stall_done = 0;

	logic [15:0] sh_count = 16'd2;
	logic sh_poles = 0, sh_fixed = 0;
	logic [23:0] sh_angle = '0;
	longint unsigned pidx = 0;
	logic [23:0] phs = '0;

	localparam longint ATAN_TBL[30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2};

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint scale_ring(input longint t, input longint r);
		longint v;
		v = (t * r + (64'sd1 <<< 29)) >>> 30;
		if (v > 16384)
			v = 16384;
		if (v < -16384)
			v = -16384;
		return v;
	endfunction

	function point_t next_point(input logic rs);
		longint unsigned n, k, nn, i, d, mag, step, m, root, q, r32;
		longint a, yv, r, cx, cy, ang, dx, dy, s, c;
		point_t p;
		bit last;
		n = (sh_count != 0) ? 64'(sh_count) : 64'd1;
		if (rs || pidx >= n)
			pidx = 0;
		if (pidx == 0)
			phs = '0;
		k = pidx;
		last = (k == n - 1);
		nn = sh_poles ? n : n + 2;
		i = sh_poles ? k : k + 1;
		p = '0;
		if (sh_poles && (k == 0 || last)) begin
			phs = '0;
			p.y = (k == 0) ? -16'sd16384 : 16'sd16384;
		end else begin
			d = nn - 1;
			a = longint'(2 * i) - longint'(d);
			mag = (a < 0) ? longint'(-a) : a;
			mag = ((mag << 15) + d) / (2 * d);
			yv = (a < 0) ? -longint'(mag) : longint'(mag);
			r = int_sqrt((64'd1 << 28) - longint'(yv * yv));
			if (sh_fixed) begin
				step = 64'(sh_angle);
			end else begin
				m = nn * i * (nn - 1 - i);
				root = int_sqrt(m << 16);
				q = root ? ((64'd1230417496 * d) << 8) / root : 0;
				step = q >> 8;
			end
			phs = phs + step[23:0];
			r32 = longint'(phs[21:0]) << 8;
			ang = (r32 * 64'd3373259426) >> 31;
			cx = 652032874;
			cy = 0;
			for (int j = 0; j < 30; j++) begin
				dx = cy >>> j;
				dy = cx >>> j;
				if (ang >= 0) begin
					cx -= dx; cy += dy; ang -= ATAN_TBL[j];
				end else begin
					cx += dx; cy -= dy; ang += ATAN_TBL[j];
				end
			end
			case (phs[23:22])
				2'd0: begin s = cy; c = cx; end
				2'd1: begin s = cx; c = -cy; end
				2'd2: begin s = -cy; c = -cx; end
				default: begin s = -cx; c = cy; end
			endcase
			p.y = yv[15:0];
			p.x = 16'(scale_ring(s, r));
			p.z = 16'(scale_ring(c, r));
		end
		p.last = last;
		pidx = last ? 0 : k + 1;
		return p;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		if (in_valid && in_ready) begin
			exp_points.insert(exp_points.size(), next_point(restart));
			taken <= taken + 1;
		end
		if (out_valid && out_ready) begin
			if (exp_points.size() == 0) begin
				$display("%0t: unexpected point x=%0d y=%0d z=%0d last=%0b",
					$time, x_coord, y_coord, z_coord, last_point);
				errors++;
			end else begin
				point_t e;
				e = exp_points.pop_front();
				if (x_coord !== e.x) begin
					$display("%0t: x expected %0d actual %0d", $time, e.x, x_coord);
					errors++;
				end
				if (y_coord !== e.y) begin
					$display("%0t: y expected %0d actual %0d", $time, e.y, y_coord);
					errors++;
				end
				if (z_coord !== e.z) begin
					$display("%0t: z expected %0d actual %0d", $time, e.z, z_coord);
					errors++;
				end
				if (last_point !== e.last) begin
					$display("%0t: last expected %0b actual %0b", $time, e.last,
						last_point);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (in_valid && sent != taken) begin
			// hold until the transfer
		end else if (send_gap > 0 && !quiet) begin
			in_valid <= 0;
			send_gap <= send_gap - 1;
		end else if (pend_restart.size() != 0) begin
			in_valid <= 1;
			restart <= pend_restart.pop_front();
			sent <= sent + 1;
			if (!quiet && $urandom_range(0, 3) == 0)
				send_gap <= $urandom_range(1, 14);
		end else begin
			in_valid <= 0;
		end
	end

	always @(negedge clk) begin
		if (stall_req && !stall_done) begin
			stall_done <= 1;
			stall_left <= 2000;
			out_ready <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 0;
		end else if (quiet) begin
			out_ready <= 1;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			if ($urandom_range(0, 7) == 0)
				recv_gap <= $urandom_range(1, 14);
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		case (idx)
			REG_POINT_COUNT: sh_count = v[15:0];
			REG_POLES: sh_poles = v[0];
			REG_FIXED_EN: sh_fixed = v[0];
			default: sh_angle = v[23:0];
		endcase
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_all(input logic [15:0] cnt, input logic pl, input logic fx,
		input logic [23:0] fa);
		write_reg(REG_POINT_COUNT, CFG_W'(cnt));
		write_reg(REG_POLES, CFG_W'(pl));
		write_reg(REG_FIXED_EN, CFG_W'(fx));
		write_reg(REG_FIXED_ANGLE, fa);
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pend_restart.size() != 0 || sent != taken || exp_points.size() != 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic feed(input int cnt, input int restart_pct);
		for (int j = 0; j < cnt; j++)
			pend_restart.insert(pend_restart.size(), $urandom_range(0, 99) < restart_pct);
	endtask

	initial begin
		int total;
		logic [15:0] cnt;
		logic [23:0] fa;
		repeat (12) @(negedge clk);
		arst_n <= 1;
		repeat (4) @(negedge clk);

		pend_restart = '{0, 0, 1, 0};
		drain();
		set_all(16'd1, 1, 0, 24'h0);
		pend_restart = '{0, 1, 0};
		drain();
		set_all(16'd0, 0, 1, 24'hFFFFFF);
		pend_restart = '{0, 0};
		drain();
		set_all(16'd65535, 0, 1, 24'hFFFFFF);
		pend_restart = '{0, 0, 0};
		drain();
		set_all(16'd65535, 1, 0, 24'h0);
		pend_restart = '{1, 0, 0};
		drain();
		set_all(16'd30, 1, 0, 24'h0);
		pend_restart = '{0, 0, 0, 0, 0, 0, 0, 0};
		drain();
		write_reg(REG_POINT_COUNT, CFG_W'(5));
		pend_restart = '{0, 0, 0};
		drain();

		total = 26;
		while (total < 1850) begin
			case ($urandom_range(0, 9))
				0: cnt = $urandom_range(0, 1) ? 16'd65535 : 16'($urandom_range(0, 65535));
				1, 2: cnt = 16'($urandom_range(13, 300));
				default: cnt = 16'($urandom_range(0, 12));
			endcase
			case ($urandom_range(0, 5))
				0: fa = 24'h0;
				1: fa = 24'hFFFFFF;
				default: fa = 24'($urandom_range(0, 24'hFFFFFF));
			endcase
			set_all(cnt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), fa);
			if (total > 1650)
				quiet = 1;
			if (total > 600 && !stall_req)
				stall_req = 1;
			feed($urandom_range(20, 80), $urandom_range(0, 3) == 0 ? 30 : 4);
			total += pend_restart.size();
			drain();
		end

		repeat (300) @(negedge clk);
		if (errors == 0 && exp_points.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/ssp_pkg.sv
design/ssp_front.sv
design/ssp_queue.sv
design/ssp_div.sv
design/ssp_isqrt.sv
design/ssp_cordic.sv
design/ssp_back.sv
design/sphere_spiral_point_generator.sv
tb/testbench.sv
